[src/aoc_pkg.sv]
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and constants for the alpha-over compositing pipeline.
// Holds the channel constants and the payload record that moves between the
// front end and the pipelined divider stages.
// ----------------------------------------------------------------------------
package aoc_pkg;

    // Full-scale value of one 8-bit channel.
    localparam logic [7:0] CHAN_MAX = 8'd255;

    // Number of color channels that go through the divider.
    localparam int NUM_CHAN = 3;

    // Quotient bits resolved in each divider stage, and the stage count.
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = 8 / STEPS_PER_STAGE;

    typedef logic [7:0]  t_chan;
    typedef logic [15:0] t_cov;

    // Payload of one pixel inside the divider.
    // rem holds the partial remainder, quo the numerator bits not yet used
    // in its upper part and the quotient bits gathered so far in its lower part.
    typedef struct packed {
        logic [NUM_CHAN-1:0][15:0] rem;
        logic [NUM_CHAN-1:0][7:0]  quo;
        t_cov                      den;
        t_chan                     alpha;
        logic                      zero;
    } t_div;

endpackage

[src/aoc_front.sv]
// ----------------------------------------------------------------------------
// aoc_front: coverage and numerator stages of the alpha-over pipeline.
// Stage A forms the weighted background coverage and the foreground products,
// stage B forms the three color numerators, the scaled coverage and the
// output alpha, and loads the divider record.
// ----------------------------------------------------------------------------
module aoc_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [aoc_pkg::NUM_CHAN-1:0][7:0]     i_fg,
    input  aoc_pkg::t_chan                        i_fg_alpha,
    input  logic [aoc_pkg::NUM_CHAN-1:0][7:0]     i_bg,
    input  aoc_pkg::t_chan                        i_bg_alpha,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output aoc_pkg::t_div                         o_data
);

    // Stage A registers.
    logic                                  r_a_vld;
    aoc_pkg::t_chan                        r_a;
    aoc_pkg::t_cov                         r_w;
    logic [aoc_pkg::NUM_CHAN-1:0][15:0]    r_fp;
    logic [aoc_pkg::NUM_CHAN-1:0][7:0]     r_cb;

    // Stage A next values.
    aoc_pkg::t_cov                         n_w;
    logic [aoc_pkg::NUM_CHAN-1:0][15:0]    n_fp;

    // Stage B registers and next value.
    logic                                  r_b_vld;
    aoc_pkg::t_div                         r_b_data;
    aoc_pkg::t_div                         n_b_data;

    logic                                  ready_a;
    logic                                  ready_b;

    // A stage takes a new item when it is empty or its content moves on.
    assign ready_b = !r_b_vld || i_ready;
    assign ready_a = !r_a_vld || ready_b;
    assign o_ready = ready_a;

    // Stage A: background weight b*(255-a) and foreground products cf*a.
    always_comb begin
        n_w = 16'(i_bg_alpha) * 16'(aoc_pkg::CHAN_MAX - i_fg_alpha);
        for (int ch = 0; ch < aoc_pkg::NUM_CHAN; ch++) begin
            n_fp[ch] = 16'(i_fg[ch]) * 16'(i_fg_alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (ready_a) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_a  <= i_fg_alpha;
            r_w  <= n_w;
            r_fp <= n_fp;
            r_cb <= i_bg;
        end
    end

    // Stage B: numerators 255*cf*a + cb*w, coverage D = 255*a + w, and
    // alpha = floor(D/255) through the reciprocal form (D + 1 + D/256) / 256.
    always_comb begin
        logic [16:0] den_sum;
        logic [16:0] alpha_sum;
        logic [23:0] num;
        den_sum   = 17'({r_a, 8'h00}) - 17'(r_a) + 17'(r_w);
        n_b_data.den   = den_sum[15:0];
        alpha_sum = 17'(den_sum[15:0]) + 17'd1 + 17'(den_sum[15:8]);
        n_b_data.alpha = alpha_sum[15:8];
        n_b_data.zero  = (den_sum[15:0] == 16'd0);
        for (int ch = 0; ch < aoc_pkg::NUM_CHAN; ch++) begin
            num = 24'({r_fp[ch], 8'h00}) - 24'(r_fp[ch])
                + 24'(r_cb[ch]) * 24'(r_w);
            // The upper part is already below D, so it seeds the remainder.
            n_b_data.rem[ch] = num[23:8];
            n_b_data.quo[ch] = num[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (ready_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_a_vld) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_valid = r_b_vld;
    assign o_data  = r_b_data;

endmodule

[src/aoc_div_stage.sv]
// ----------------------------------------------------------------------------
// aoc_div_stage: one stage of the pipelined restoring divider.
// Resolves two quotient bits for each color channel by shifting the next
// numerator bit into the partial remainder and subtracting the coverage
// where it fits.
// ----------------------------------------------------------------------------
module aoc_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  aoc_pkg::t_div  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output aoc_pkg::t_div  o_data
);

    logic           r_vld;
    aoc_pkg::t_div  r_data;
    aoc_pkg::t_div  n_data;

    assign o_ready = !r_vld || i_ready;

    // Two shift-compare-subtract steps per channel.
    always_comb begin
        logic [16:0] trial;
        logic [15:0] rem;
        logic [7:0]  quo;
        logic        fits;
        n_data = i_data;
        for (int ch = 0; ch < aoc_pkg::NUM_CHAN; ch++) begin
            rem = i_data.rem[ch];
            quo = i_data.quo[ch];
            for (int s = 0; s < aoc_pkg::STEPS_PER_STAGE; s++) begin
                trial = {rem, quo[7]};
                fits  = (trial >= {1'b0, i_data.den});
                if (fits) begin
                    trial = trial - {1'b0, i_data.den};
                end
                rem = trial[15:0];
                quo = {quo[6:0], fits};
            end
            n_data.rem[ch] = rem;
            n_data.quo[ch] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

[src/alpha_over_composite_unit.sv]
// Throughput: one pixel per cycle while i_stall is low; two front stages,
// then four divider stages that each resolve two quotient bits of the three
// color channels. A stalled result holds only the stages behind it that are
// full; empty stages keep taking pixels. Reset clears the stage valid bits
// only.
// ----------------------------------------------------------------------------
// alpha_over_composite_unit: straight-alpha RGBA8 "over" compositor.
// Composites one foreground pixel onto one background pixel per transfer,
// with exact integer arithmetic and truncation.
// ----------------------------------------------------------------------------
module alpha_over_composite_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_fg_red,
    input  logic [7:0] i_fg_green,
    input  logic [7:0] i_fg_blue,
    input  logic [7:0] i_fg_alpha,
    input  logic [7:0] i_bg_red,
    input  logic [7:0] i_bg_green,
    input  logic [7:0] i_bg_blue,
    input  logic [7:0] i_bg_alpha,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);

    logic                                  vld [0:aoc_pkg::DIV_STAGES];
    logic                                  rdy [0:aoc_pkg::DIV_STAGES];
    aoc_pkg::t_div                         dat [0:aoc_pkg::DIV_STAGES];
    logic [aoc_pkg::NUM_CHAN-1:0][7:0]     fg;
    logic [aoc_pkg::NUM_CHAN-1:0][7:0]     bg;
    logic                                  front_ready;
    aoc_pkg::t_div                         last;

    assign fg = {i_fg_blue, i_fg_green, i_fg_red};
    assign bg = {i_bg_blue, i_bg_green, i_bg_red};

    // Products, numerators, coverage and alpha.
    aoc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (front_ready),
        .i_fg       (fg),
        .i_fg_alpha (i_fg_alpha),
        .i_bg       (bg),
        .i_bg_alpha (i_bg_alpha),
        .o_valid    (vld[0]),
        .i_ready    (rdy[0]),
        .o_data     (dat[0])
    );

    assign o_stall = !front_ready;

    // Divider chain, two quotient bits per stage.
    for (genvar g = 0; g < aoc_pkg::DIV_STAGES; g++) begin : g_div
        aoc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .o_ready (rdy[g]),
            .i_data  (dat[g]),
            .o_valid (vld[g+1]),
            .i_ready (rdy[g+1]),
            .o_data  (dat[g+1])
        );
    end

    assign rdy[aoc_pkg::DIV_STAGES] = !i_stall;
    assign last = dat[aoc_pkg::DIV_STAGES];

    // Result: zero coverage gives an all-zero pixel.
    assign o_valid     = vld[aoc_pkg::DIV_STAGES];
    assign o_out_red   = last.zero ? 8'd0 : last.quo[0];
    assign o_out_green = last.zero ? 8'd0 : last.quo[1];
    assign o_out_blue  = last.zero ? 8'd0 : last.quo[2];
    assign o_out_alpha = last.alpha;

    // With the output side free, every stage can move, so the input is open.
    a_open_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while the output side takes transfers");

    // The finished remainder of every channel lies below the coverage.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !last.zero) |->
        (last.rem[0] < last.den) && (last.rem[1] < last.den)
        && (last.rem[2] < last.den))
        else $error("divider remainder not reduced below the coverage");

    // Alpha is the floor of the coverage over 255.
    a_alpha_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
        (17'(last.alpha) * 17'(aoc_pkg::CHAN_MAX) <= 17'(last.den))
        && (17'(last.den) < 17'(last.alpha) * 17'(aoc_pkg::CHAN_MAX)
        + 17'(aoc_pkg::CHAN_MAX)))
        else $error("output alpha does not match the coverage");

    // Zero coverage travels with a zero alpha.
    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && last.zero) |-> (o_out_alpha == 8'd0))
        else $error("zero coverage with a nonzero alpha");

endmodule

[sim/alpha_over_composite_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_composite_unit_test: self-checking bench for the over compositor.
// Drives pixel pairs through the valid/stall input channel. Each accepted pair
// is run through an exact integer model of straight-alpha "over", and the
// predicted pixel is queued. Every result transfer is checked field by field
// against the oldest queued pixel. Both sides idle at random, and one phase
// holds the output off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module alpha_over_composite_unit_test;

    localparam int unsigned FULL_SCALE  = 32'(aoc_pkg::CHAN_MAX);
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_WAIT  = 16;

    // One foreground/background pixel pair as it enters the block.
    typedef struct packed {
        aoc_pkg::t_chan fg_red;
        aoc_pkg::t_chan fg_green;
        aoc_pkg::t_chan fg_blue;
        aoc_pkg::t_chan fg_alpha;
        aoc_pkg::t_chan bg_red;
        aoc_pkg::t_chan bg_green;
        aoc_pkg::t_chan bg_blue;
        aoc_pkg::t_chan bg_alpha;
    } t_pixel_pair;

    // One composited pixel as it leaves the block.
    typedef struct packed {
        aoc_pkg::t_chan red;
        aoc_pkg::t_chan green;
        aoc_pkg::t_chan blue;
        aoc_pkg::t_chan alpha;
    } t_composite;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_pixel_pair drv_px = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_composite  out_px;

    t_composite  pending_px[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    int unsigned sink_hold_cycles = 0;

    alpha_over_composite_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_fg_red    (drv_px.fg_red),
        .i_fg_green  (drv_px.fg_green),
        .i_fg_blue   (drv_px.fg_blue),
        .i_fg_alpha  (drv_px.fg_alpha),
        .i_bg_red    (drv_px.bg_red),
        .i_bg_green  (drv_px.bg_green),
        .i_bg_blue   (drv_px.bg_blue),
        .i_bg_alpha  (drv_px.bg_alpha),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_out_red   (out_px.red),
        .o_out_green (out_px.green),
        .o_out_blue  (out_px.blue),
        .o_out_alpha (out_px.alpha)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, in case a transfer never completes.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One color channel of the over blend, truncated toward zero.
    function automatic aoc_pkg::t_chan blend_chan(int unsigned cf, int unsigned cb,
                                                  int unsigned a, int unsigned b,
                                                  int unsigned cov);
        int unsigned num;
        num = FULL_SCALE * cf * a + cb * b * (FULL_SCALE - a);
        return aoc_pkg::t_chan'(num / cov);
    endfunction

    // Straight-alpha over of one pixel pair, in exact integer arithmetic.
    function automatic t_composite composite_over(t_pixel_pair px);
        int unsigned a;
        int unsigned b;
        int unsigned cov;
        t_composite  res;
        a   = 32'(px.fg_alpha);
        b   = 32'(px.bg_alpha);
        cov = FULL_SCALE * a + b * (FULL_SCALE - a);
        // Two fully transparent pixels give an all-zero pixel.
        if (cov == 0) begin
            res = '0;
        end else begin
            res.red   = blend_chan(32'(px.fg_red), 32'(px.bg_red), a, b, cov);
            res.green = blend_chan(32'(px.fg_green), 32'(px.bg_green), a, b, cov);
            res.blue  = blend_chan(32'(px.fg_blue), 32'(px.bg_blue), a, b, cov);
            res.alpha = aoc_pkg::t_chan'(cov / FULL_SCALE);
        end
        return res;
    endfunction

    function automatic t_pixel_pair make_pixel(aoc_pkg::t_chan fr, aoc_pkg::t_chan fg,
                                               aoc_pkg::t_chan fb, aoc_pkg::t_chan fa,
                                               aoc_pkg::t_chan br, aoc_pkg::t_chan bg,
                                               aoc_pkg::t_chan bb, aoc_pkg::t_chan ba);
        t_pixel_pair px;
        px = '{fr, fg, fb, fa, br, bg, bb, ba};
        return px;
    endfunction

    // Alphas lean toward the transparent and opaque ends, where the
    // special cases live; colors are uniform.
    function automatic aoc_pkg::t_chan random_alpha();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 8'd0;
        end else if (pick == 1) begin
            return 8'd255;
        end
        return aoc_pkg::t_chan'($urandom_range(0, 255));
    endfunction

    function automatic t_pixel_pair random_pixel();
        t_pixel_pair px;
        px = t_pixel_pair'({$urandom(), $urandom()});
        px.fg_alpha = random_alpha();
        px.bg_alpha = random_alpha();
        return px;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one pixel pair after a random gap and waits for its transfer.
    task automatic send_pixel(input t_pixel_pair px);
        int unsigned gap;
        gap = src_idle_en ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        drv_px   <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_px.push_back(composite_over(px));
    endtask

    // Output side: a random stall before each transfer, plus any long
    // hold-off that a test has asked for.
    initial begin
        int unsigned wait_cycles;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            wait_cycles = sink_idle_en ? $urandom_range(0, 8) : 0;
            wait_cycles += sink_hold_cycles;
            sink_hold_cycles = 0;
            if (wait_cycles != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Checks each result transfer against the oldest predicted pixel.
    always @(posedge clk) begin
        t_composite want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_px.size() == 0) begin
                report_error("result with no pixel pair outstanding");
            end else begin
                want = pending_px.pop_front();
                if (out_px.red !== want.red)
                    report_error($sformatf("red %0d, expected %0d", out_px.red, want.red));
                if (out_px.green !== want.green)
                    report_error($sformatf("green %0d, expected %0d",
                                           out_px.green, want.green));
                if (out_px.blue !== want.blue)
                    report_error($sformatf("blue %0d, expected %0d", out_px.blue, want.blue));
                if (out_px.alpha !== want.alpha)
                    report_error($sformatf("alpha %0d, expected %0d",
                                           out_px.alpha, want.alpha));
            end
        end
    end

    // Corner pixels: transparent pairs, opaque foreground, extreme alphas
    // and colors, alternating bit patterns.
    task automatic test_corner_pixels();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd170, 8'd0, 8'd0, 8'd255, 8'd85, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd170, 8'd255, 8'd85, 8'd85, 8'd85, 8'd255));
        send_pixel(make_pixel(8'd12, 8'd200, 8'd99, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0));
        send_pixel(make_pixel(8'd1, 8'd128, 8'd254, 8'd255, 8'd77, 8'd3, 8'd250, 8'd128));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd254, 8'd1, 8'd1));
        send_pixel(make_pixel(8'd255, 8'd128, 8'd7, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd1));
        send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd254, 8'd255, 8'd0, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd128, 8'd128, 8'd0, 8'd255, 8'd127, 8'd128));
        send_pixel(make_pixel(8'd90, 8'd180, 8'd45, 8'd127, 8'd240, 8'd15, 8'd60, 8'd200));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd100, 8'd0, 8'd0, 8'd0, 8'd200));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd100, 8'd255, 8'd255, 8'd255, 8'd200));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA));
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd254));
    endtask

    // Random pixels with idling switched on and off in stretches on each side.
    task automatic test_random_idle(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_pixel(random_pixel());
        end
    endtask

    // Back-to-back pixels with neither side idling.
    task automatic test_streaming(input int unsigned count);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (count) send_pixel(random_pixel());
    endtask

    // The output is held off for long stretches while pixels keep coming,
    // so the pipeline fills and stalls its input.
    task automatic test_backpressure(input int unsigned bursts);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b1;
        repeat (bursts) begin
            sink_hold_cycles = $urandom_range(40, 80);
            repeat (30) send_pixel(random_pixel());
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_pixels();
        test_random_idle(500);
        test_streaming(200);
        test_backpressure(5);

        // Close the input channel and let the pipeline drain.
        in_valid <= 1'b0;
        sink_idle_en = 1'b1;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
